// File: hw/rtl/png_chunk_deframer_macros.svh
// Assertion macros shared by the PNG chunk deframer RTL.
// Included by every module that carries concurrent checks; no other dependency.
`ifndef PNG_CHUNK_DEFRAMER_MACROS_SVH
`define PNG_CHUNK_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define PCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Antecedent at one edge implies consequent at the next
`define PCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PCD_ASSERT(lbl, clk, rst_n, prop)
`define PCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/pcd_pkg.sv
// Types and constants for the PNG chunk deframer.
// No dependencies; used by pcd_parser, pcd_out_buf and png_chunk_deframer.
package pcd_pkg;

    // Parse phase
    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5,
        PH_HALT = 3'd6
    } t_phase;

    // Result status codes
    localparam logic [1:0] ST_CHUNK   = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // Chunk type codes, first byte in the top bits
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;
    localparam logic [31:0] TYPE_IHDR = 32'h49484452;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] chunk_length;
        logic [31:0] chunk_type;
        logic [31:0] chunk_crc;
        logic [15:0] chunk_number;
        logic        is_end_chunk;
        logic        order_ok;
    } t_result;

    // File signature byte by position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'd137;
            3'd1:    b = 8'd80;
            3'd2:    b = 8'd78;
            3'd3:    b = 8'd71;
            3'd4:    b = 8'd13;
            3'd5:    b = 8'd10;
            3'd6:    b = 8'd26;
            3'd7:    b = 8'd10;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/png_chunk_deframer.sv
// PNG chunk deframer top level: parser plus buffered result channel.
// Depends on pcd_pkg, pcd_parser and pcd_out_buf.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+----------------------------------------
//   input   | i_in_valid   | o_in_ready   | i_data_byte, i_last_byte
//   output  | o_out_valid  | i_out_ready  | o_status, o_chunk_*, o_is_end_chunk, o_order_ok
//
// One byte is taken per cycle while o_in_ready is high; its result, if any, is registered into the result buffer.
// The parse update is a single registered step per byte (shift, count, compare).
// A two-word result buffer lets two results wait; o_in_ready drops only when both are full.
// Synchronous active-low reset returns the parser to the signature phase, buffer empty.
module png_chunk_deframer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_chunk_length,
    output logic [31:0] o_chunk_type,
    output logic [31:0] o_chunk_crc,
    output logic [15:0] o_chunk_number,
    output logic        o_is_end_chunk,
    output logic        o_order_ok
);

    logic             accept;
    logic             res_valid;
    pcd_pkg::t_result res, out_res;

    assign accept = i_in_valid && o_in_ready;

    // Parser
    pcd_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result buffer
    pcd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept && res_valid),
        .i_push_res   (res),
        .o_ready      (o_in_ready),
        .o_valid      (o_out_valid),
        .i_take_ready (i_out_ready),
        .o_res        (out_res)
    );

    assign o_status       = out_res.status;
    assign o_chunk_length = out_res.chunk_length;
    assign o_chunk_type   = out_res.chunk_type;
    assign o_chunk_crc    = out_res.chunk_crc;
    assign o_chunk_number = out_res.chunk_number;
    assign o_is_end_chunk = out_res.is_end_chunk;
    assign o_order_ok     = out_res.order_ok;

endmodule

// File: hw/rtl/pcd_parser.sv
// Byte-at-a-time chunk parser: parse state registers and next-state logic.
// Depends on pcd_pkg and png_chunk_deframer_macros.svh.
`include "png_chunk_deframer_macros.svh"
module pcd_parser #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_res_valid,
    output pcd_pkg::t_result o_res
);

    pcd_pkg::t_phase        r_phase, n_phase;
    logic [3:0]             r_cnt, n_cnt;
    logic [31:0]            r_len, n_len;
    logic [31:0]            r_type, n_type;
    logic [31:0]            r_crc, n_crc;
    logic [31:0]            r_rem, n_rem;
    logic [COUNT_WIDTH-1:0] r_seen, n_seen;
    logic                   r_first, n_first;

    logic [31:0] len_next, type_next, crc_next, rem_dec, seen_ext;
    logic        trunc_chk;

    assign len_next  = {r_len[23:0], i_data_byte};
    assign type_next = {r_type[23:0], i_data_byte};
    assign crc_next  = {r_crc[23:0], i_data_byte};
    assign rem_dec   = r_rem - 32'd1;
    assign seen_ext  = 32'(r_seen);

    // Next state and result for the word being accepted
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_type      = r_type;
        n_crc       = r_crc;
        n_rem       = r_rem;
        n_seen      = r_seen;
        n_first     = r_first;
        o_res_valid = 1'b0;
        o_res       = '0;
        trunc_chk   = 1'b0;
        case (r_phase)
            pcd_pkg::PH_SIG: begin
                if (i_data_byte != pcd_pkg::sig_byte(r_cnt[2:0])) begin
                    o_res_valid  = 1'b1;
                    o_res.status = pcd_pkg::ST_BAD_SIG;
                    n_phase      = pcd_pkg::PH_HALT;
                end else begin
                    trunc_chk = 1'b1;
                    if (r_cnt == 4'd7) begin
                        n_cnt   = 4'd0;
                        n_phase = pcd_pkg::PH_LEN;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            pcd_pkg::PH_LEN: begin
                n_len     = len_next;
                trunc_chk = 1'b1;
                if (r_cnt == 4'd3) begin
                    n_cnt   = 4'd0;
                    n_phase = pcd_pkg::PH_TYPE;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            pcd_pkg::PH_TYPE: begin
                n_type    = type_next;
                trunc_chk = 1'b1;
                if (r_cnt == 4'd3) begin
                    n_cnt = 4'd0;
                    if (r_seen == '0) begin
                        n_first = (type_next == pcd_pkg::TYPE_IHDR);
                    end
                    n_rem   = r_len;
                    n_phase = (r_len == 32'd0) ? pcd_pkg::PH_CRC : pcd_pkg::PH_DATA;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            pcd_pkg::PH_DATA: begin
                n_rem     = rem_dec;
                trunc_chk = 1'b1;
                if (rem_dec == 32'd0) begin
                    n_phase = pcd_pkg::PH_CRC;
                end
            end
            pcd_pkg::PH_CRC: begin
                n_crc = crc_next;
                if (r_cnt == 4'd3) begin
                    n_cnt              = 4'd0;
                    o_res_valid        = 1'b1;
                    o_res.status       = pcd_pkg::ST_CHUNK;
                    o_res.chunk_length = r_len;
                    o_res.chunk_type   = r_type;
                    o_res.chunk_crc    = crc_next;
                    o_res.chunk_number = seen_ext[15:0];
                    o_res.is_end_chunk = (r_type == pcd_pkg::TYPE_IEND);
                    o_res.order_ok     = r_first;
                    if (r_seen != {COUNT_WIDTH{1'b1}}) begin
                        n_seen = r_seen + COUNT_WIDTH'(1);
                    end
                    if (r_type == pcd_pkg::TYPE_IEND) begin
                        n_phase = pcd_pkg::PH_DONE;
                    end else if (i_last_byte) begin
                        o_res.status = pcd_pkg::ST_TRUNC;
                        n_phase      = pcd_pkg::PH_HALT;
                    end else begin
                        n_phase = pcd_pkg::PH_LEN;
                    end
                end else begin
                    n_cnt     = r_cnt + 4'd1;
                    trunc_chk = 1'b1;
                end
            end
            default: ;
        endcase
        // Final byte before IEND: truncation, fields cleared
        if (trunc_chk && i_last_byte) begin
            o_res_valid  = 1'b1;
            o_res        = '0;
            o_res.status = pcd_pkg::ST_TRUNC;
            n_phase      = pcd_pkg::PH_HALT;
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcd_pkg::PH_SIG;
            r_cnt   <= 4'd0;
            r_len   <= 32'd0;
            r_type  <= 32'd0;
            r_crc   <= 32'd0;
            r_rem   <= 32'd0;
            r_seen  <= '0;
            r_first <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_type  <= n_type;
            r_crc   <= n_crc;
            r_rem   <= n_rem;
            r_seen  <= n_seen;
            r_first <= n_first;
        end
    end

    // Checks; a halt from the signature phase keeps its signature count
    `PCD_ASSERT(a_quiet_when_stopped, i_clk, i_rst_n,
        (i_accept && (r_phase == pcd_pkg::PH_HALT || r_phase == pcd_pkg::PH_DONE)) |-> !o_res_valid)
    `PCD_ASSERT(a_data_nonzero, i_clk, i_rst_n,
        (r_phase == pcd_pkg::PH_DATA) |-> (r_rem != 32'd0))
    `PCD_ASSERT(a_field_count_range, i_clk, i_rst_n,
        (r_phase != pcd_pkg::PH_SIG && r_phase != pcd_pkg::PH_HALT) |-> (r_cnt < 4'd4))

endmodule

// File: hw/rtl/pcd_out_buf.sv
// Result register with a one-word skid stage, so the parser runs on while a
// result waits. Depends on pcd_pkg and png_chunk_deframer_macros.svh.
`include "png_chunk_deframer_macros.svh"
module pcd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcd_pkg::t_result i_push_res,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_take_ready,
    output pcd_pkg::t_result o_res
);

    logic             r_out_valid, r_skid_valid;
    pcd_pkg::t_result r_out, r_skid;
    logic             take;

    assign take    = r_out_valid && i_take_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : i_push_res;
        end else if (i_push) begin
            r_skid <= i_push_res;
        end
    end

    // Checks
    `PCD_ASSERT(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    `PCD_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        i_push && r_out_valid && !i_take_ready, r_skid_valid)
    `PCD_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n,
        r_skid_valid && take, r_out_valid && !r_skid_valid)

endmodule

// File: tb/sv/tb_png_chunk_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for png_chunk_deframer: feeds one PNG stream word by word.
// It predicts each chunk record in-bench and checks the result channel; depends on pcd_pkg.
module tb_png_chunk_deframer;

    localparam logic [63:0] PNG_MAGIC   = 64'h89504E470D0A1A0A;
    localparam logic [31:0] TYPE_IDAT   = 32'h49444154;
    localparam int          RANDOM_WORDS = 1550;
    localparam int          LONG_STALL  = 400;
    localparam int          TAIL_CYCLES = 20;

    // How a table row is checked
    localparam logic CHK_MODEL = 1'b0;
    localparam logic CHK_TABLE = 1'b1;

    // How the stream is closed off
    typedef enum int {
        FINISH_IEND,
        FINISH_CUT,
        FINISH_ON_CRC
    } t_finish;

    localparam pcd_pkg::t_result NO_REC   = '0;
    localparam pcd_pkg::t_result IHDR_REC = {pcd_pkg::ST_CHUNK, 32'd0, pcd_pkg::TYPE_IHDR,
                                             32'hFF008001, 16'd0, 1'b0, 1'b1};

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic             by_table;
        logic             has_rec;
        pcd_pkg::t_result rec;
    } t_row;

    // Signature, then an empty IHDR chunk with extreme CRC bytes
    localparam int INTRO_ROWS = 20;
    localparam t_row INTRO [INTRO_ROWS] = '{
        {8'd137, 1'b0, CHK_TABLE, 1'b0, NO_REC},
        {8'd80,  1'b0, CHK_TABLE, 1'b0, NO_REC},
        {8'd78,  1'b0, CHK_TABLE, 1'b0, NO_REC},
        {8'd71,  1'b0, CHK_TABLE, 1'b0, NO_REC},
        {8'd13,  1'b0, CHK_TABLE, 1'b0, NO_REC},
        {8'd10,  1'b0, CHK_TABLE, 1'b0, NO_REC},
        {8'd26,  1'b0, CHK_TABLE, 1'b0, NO_REC},
        {8'd10,  1'b0, CHK_TABLE, 1'b0, NO_REC},
        {8'h00,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h00,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h00,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h00,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h49,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h48,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h44,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h52,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'hFF,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h00,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h80,  1'b0, CHK_MODEL, 1'b0, NO_REC},
        {8'h01,  1'b0, CHK_TABLE, 1'b1, IHDR_REC}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_chunk_length;
    logic [31:0] o_chunk_type;
    logic [31:0] o_chunk_crc;
    logic [15:0] o_chunk_number;
    logic        o_is_end_chunk;
    logic        o_order_ok;

    png_chunk_deframer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_chunk_length (o_chunk_length),
        .o_chunk_type   (o_chunk_type),
        .o_chunk_crc    (o_chunk_crc),
        .o_chunk_number (o_chunk_number),
        .o_is_end_chunk (o_is_end_chunk),
        .o_order_ok     (o_order_ok)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pcd_pkg::t_result records_due [$];
    logic [7:0]       chunk_bytes [$];
    int               fault_count = 0;
    int               bytes_fed = 0;
    int               send_gap_pct = 14;
    int               take_gap_pct = 55;
    int               stall_asked = 0;
    int               stall_taken = 0;
    int               stall_left = 0;

    // Deframer state as the bench sees it
    pcd_pkg::t_phase ph = pcd_pkg::PH_SIG;
    logic [3:0]      field_cnt = '0;
    logic [31:0]     len_acc = '0;
    logic [31:0]     type_acc = '0;
    logic [31:0]     crc_acc = '0;
    logic [31:0]     data_left = '0;
    logic [15:0]     chunk_idx = '0;
    logic            first_hdr = 1'b0;

    // Advance the parse by one file byte; returns 1 when a record is due
    function automatic logic deframe_byte(input logic [7:0] b, input logic last,
                                          output pcd_pkg::t_result rec);
        rec = '0;
        case (ph)
            pcd_pkg::PH_SIG: begin
                if (b != PNG_MAGIC[63 - 8 * field_cnt[2:0] -: 8]) begin
                    rec.status = pcd_pkg::ST_BAD_SIG;
                    ph = pcd_pkg::PH_HALT;
                    return 1'b1;
                end
                field_cnt++;
                if (field_cnt >= 4'd8) begin
                    field_cnt = '0;
                    ph = pcd_pkg::PH_LEN;
                end
            end
            pcd_pkg::PH_LEN: begin
                len_acc = {len_acc[23:0], b};
                field_cnt++;
                if (field_cnt >= 4'd4) begin
                    field_cnt = '0;
                    ph = pcd_pkg::PH_TYPE;
                end
            end
            pcd_pkg::PH_TYPE: begin
                type_acc = {type_acc[23:0], b};
                field_cnt++;
                if (field_cnt >= 4'd4) begin
                    field_cnt = '0;
                    if (chunk_idx == '0)
                        first_hdr = (type_acc == pcd_pkg::TYPE_IHDR);
                    data_left = len_acc;
                    ph = (data_left == '0) ? pcd_pkg::PH_CRC : pcd_pkg::PH_DATA;
                end
            end
            pcd_pkg::PH_DATA: begin
                data_left--;
                if (data_left == '0)
                    ph = pcd_pkg::PH_CRC;
            end
            pcd_pkg::PH_CRC: begin
                crc_acc = {crc_acc[23:0], b};
                field_cnt++;
                if (field_cnt >= 4'd4) begin
                    field_cnt = '0;
                    rec.status       = pcd_pkg::ST_CHUNK;
                    rec.chunk_length = len_acc;
                    rec.chunk_type   = type_acc;
                    rec.chunk_crc    = crc_acc;
                    rec.chunk_number = chunk_idx;
                    rec.is_end_chunk = (type_acc == pcd_pkg::TYPE_IEND);
                    rec.order_ok     = first_hdr;
                    if (chunk_idx != 16'hFFFF)
                        chunk_idx++;
                    // IEND wins over a last flag on the same byte
                    if (rec.is_end_chunk) begin
                        ph = pcd_pkg::PH_DONE;
                    end else if (last) begin
                        rec.status = pcd_pkg::ST_TRUNC;
                        ph = pcd_pkg::PH_HALT;
                    end else begin
                        ph = pcd_pkg::PH_LEN;
                    end
                    return 1'b1;
                end
            end
            default: return 1'b0;
        endcase
        // Stream ran out before IEND
        if (last) begin
            rec = '0;
            rec.status = pcd_pkg::ST_TRUNC;
            ph = pcd_pkg::PH_HALT;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one word and wait for it to be taken, then log what it should produce
    task automatic feed(input logic [7:0] b, input logic last, input logic by_table,
                        input logic tab_has, input pcd_pkg::t_result tab_rec);
        logic             got;
        pcd_pkg::t_result rec;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        got = deframe_byte(b, last, rec);
        if (by_table) begin
            got = tab_has;
            rec = tab_rec;
        end
        if (got)
            records_due = {records_due, rec};
        bytes_fed++;
    endtask

    // Hold the sender until every record due has come out
    task automatic drain();
        if (records_due.size() != 0) begin
            i_in_valid <= 1'b0;
            while (records_due.size() != 0)
                @(posedge i_clk);
        end
    endtask

    // Build one well-formed chunk: mostly short data, now and then a long one
    function automatic void make_chunk(input logic end_it);
        logic [31:0] len;
        logic [31:0] kind;
        int          pick;
        chunk_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(8);
        else if (pick < 95)
            len = $urandom_range(40, 9);
        else
            len = $urandom_range(300, 41);
        pick = $urandom_range(99);
        if (pick < 60) begin
            for (int i = 0; i < 4; i++)
                kind[31 - 8 * i -: 8] = 8'($urandom_range(25) + ($urandom_range(1) ? 65 : 97));
        end else if (pick < 80) begin
            kind = $urandom;
        end else if (pick < 90) begin
            kind = pcd_pkg::TYPE_IHDR;
        end else begin
            kind = TYPE_IDAT;
        end
        if (kind == pcd_pkg::TYPE_IEND)
            kind = ~kind;
        if (end_it) begin
            len  = '0;
            kind = pcd_pkg::TYPE_IEND;
        end
        for (int i = 0; i < 4; i++)
            chunk_bytes = {chunk_bytes, len[31 - 8 * i -: 8]};
        for (int i = 0; i < 4; i++)
            chunk_bytes = {chunk_bytes, kind[31 - 8 * i -: 8]};
        repeat (len)
            chunk_bytes = {chunk_bytes, 8'($urandom_range(255))};
        repeat (4)
            chunk_bytes = {chunk_bytes, 8'($urandom_range(255))};
    endfunction

    // Send the built chunk; the word at index cut carries the last flag and ends it
    task automatic send_chunk(input int cut);
        for (int i = 0; i < chunk_bytes.size(); i++) begin
            feed(chunk_bytes[i], i == cut, CHK_MODEL, 1'b0, NO_REC);
            if (i == cut)
                break;
        end
    endtask

    // Result side: random back-pressure plus the occasional long hold-off
    always @(posedge i_clk) begin
        if (stall_left == 0 && stall_taken != stall_asked) begin
            stall_taken = stall_asked;
            stall_left  = LONG_STALL;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    function automatic void compare_record(input pcd_pkg::t_result want,
                                           input pcd_pkg::t_result seen);
        if (seen.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            fault_count++;
        end
        if (seen.chunk_length != want.chunk_length) begin
            $error("chunk_length: expected %h, got %h", want.chunk_length, seen.chunk_length);
            fault_count++;
        end
        if (seen.chunk_type != want.chunk_type) begin
            $error("chunk_type: expected %h, got %h", want.chunk_type, seen.chunk_type);
            fault_count++;
        end
        if (seen.chunk_crc != want.chunk_crc) begin
            $error("chunk_crc: expected %h, got %h", want.chunk_crc, seen.chunk_crc);
            fault_count++;
        end
        if (seen.chunk_number != want.chunk_number) begin
            $error("chunk_number: expected %0d, got %0d", want.chunk_number,
                   seen.chunk_number);
            fault_count++;
        end
        if (seen.is_end_chunk != want.is_end_chunk) begin
            $error("is_end_chunk: expected %0d, got %0d", want.is_end_chunk,
                   seen.is_end_chunk);
            fault_count++;
        end
        if (seen.order_ok != want.order_ok) begin
            $error("order_ok: expected %0d, got %0d", want.order_ok, seen.order_ok);
            fault_count++;
        end
    endfunction

    // Check every record taken against the oldest one due
    always @(posedge i_clk) begin : watch_records
        pcd_pkg::t_result seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_status, o_chunk_length, o_chunk_type, o_chunk_crc, o_chunk_number,
                    o_is_end_chunk, o_order_ok};
            if (records_due.size() == 0) begin
                $error("record with none due: status %0d type %h", o_status, o_chunk_type);
                fault_count++;
            end else begin
                compare_record(records_due.pop_front(), seen);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_finish how;
        int      stage;
        int      cut;
        stage = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening
        for (int r = 0; r < INTRO_ROWS; r++)
            feed(INTRO[r].data, INTRO[r].last, INTRO[r].by_table, INTRO[r].has_rec,
                 INTRO[r].rec);

        // Random well-formed chunks, three idling regimes
        while (bytes_fed < RANDOM_WORDS) begin
            if (stage == 0 && bytes_fed >= RANDOM_WORDS / 3) begin
                drain();
                send_gap_pct = 55;
                take_gap_pct = 14;
                stage = 1;
            end else if (stage == 1 && bytes_fed >= 2 * RANDOM_WORDS / 3) begin
                drain();
                send_gap_pct = 0;
                take_gap_pct = 0;
                stall_asked++;
                stage = 2;
            end
            make_chunk(1'b0);
            send_chunk(-1);
        end

        // Close the stream: IEND, a cut mid-chunk, or a cut on a CRC's final byte
        how = t_finish'($urandom_range(2));
        case (how)
            FINISH_IEND: begin
                make_chunk(1'b1);
                cut = $urandom_range(1) ? chunk_bytes.size() - 1 : -1;
            end
            FINISH_CUT: begin
                make_chunk(1'b0);
                cut = $urandom_range(chunk_bytes.size() - 2);
            end
            default: begin
                make_chunk(1'b0);
                cut = chunk_bytes.size() - 1;
            end
        endcase
        send_chunk(cut);

        // Words after the end must all be ignored
        feed(8'($urandom_range(255)), 1'b1, CHK_MODEL, 1'b0, NO_REC);
        repeat (15)
            feed(8'($urandom_range(255)), 1'($urandom_range(1)), CHK_MODEL, 1'b0, NO_REC);
        i_in_valid <= 1'b0;

        while (records_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && records_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
